@@ hw/rtl/cvb_pkg.sv @@
`timescale 1ns / 1ps

package cvb_pkg;

  localparam int DIR_W         = 16;
  localparam int POS_W         = 32;
  localparam int DIR_FRAC_BITS = 14;
  localparam int NORM_GUARD    = 15;

  // normalizer widths
  localparam int NORM_IN_W  = 33;
  localparam int MAG_W      = 32;
  localparam int SH_W       = 5;
  localparam int M_W        = 16;
  localparam int SQ_W       = 2 * M_W;
  localparam int LEN_W      = SQ_W + 2;
  localparam int ROOT_W     = LEN_W + 2 * NORM_GUARD;
  localparam int SQRT_STEPS = ROOT_W / 2;
  localparam int S_W        = SQRT_STEPS;
  localparam int NUM_SHIFT  = DIR_FRAC_BITS + NORM_GUARD;
  localparam int NUM_W      = M_W + NUM_SHIFT + 1;
  localparam int QUO_W      = DIR_FRAC_BITS + 1;

  // datapath widths
  localparam int PROD_W  = 2 * DIR_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int DOTP_W  = DIR_W + POS_W;
  localparam int DOTS_W  = DOTP_W + 2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [DIR_W-1:0] back_x;
    logic signed [DIR_W-1:0] back_y;
    logic signed [DIR_W-1:0] back_z;
    logic signed [DIR_W-1:0] up_x;
    logic signed [DIR_W-1:0] up_y;
    logic signed [DIR_W-1:0] up_z;
  } cvb_in_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] right_x;
    logic signed [DIR_W-1:0] right_y;
    logic signed [DIR_W-1:0] right_z;
    logic signed [DIR_W-1:0] upward_x;
    logic signed [DIR_W-1:0] upward_y;
    logic signed [DIR_W-1:0] upward_z;
    logic signed [DIR_W-1:0] backward_x;
    logic signed [DIR_W-1:0] backward_y;
    logic signed [DIR_W-1:0] backward_z;
    logic signed [POS_W-1:0] shift_x;
    logic signed [POS_W-1:0] shift_y;
    logic signed [POS_W-1:0] shift_z;
  } cvb_out_t;

endpackage

@@ hw/rtl/camera_view_basis.sv @@
`timescale 1ns / 1ps

// channel  ports                                 payload
// input    in_valid, in_stall, in_data           cvb_in_t: position, backward, up hint
// output   out_valid, out_stall, out_data        cvb_out_t: three axes, three shifts
//
// one transfer per cycle on each side while in_stall and out_stall are low; results pass
// through the two normalizers (32-step square root, 15-step divide each)
// synchronous active-low reset clears all valid bits
// a two-entry output buffer holds results; in_stall rises only when both are full

module camera_view_basis (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cvb_pkg::cvb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cvb_pkg::cvb_out_t out_data
);
  import cvb_pkg::*;

  localparam int S1_W = 3 * POS_W + 3 * DIR_W;
  localparam int S2_W = 3 * POS_W + 3 * DIR_W + 1;
  localparam int RND_W = CROSS_W + 1;
  localparam int NEG_W = DOTS_W + 1;

  function automatic logic [DIR_W-1:0] sat_dir(input logic signed [RND_W-1:0] v);
    if (v > RND_W'(signed'(32767)))        return DIR_W'(32767);
    else if (v < -RND_W'(signed'(32768)))  return DIR_W'(-32768);
    else                                   return v[DIR_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [NEG_W-1:0] v);
    logic signed [NEG_W-1:0] hi;
    logic signed [NEG_W-1:0] lo;
    hi = NEG_W'({1'b0, {(POS_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi)      return {1'b0, {(POS_W-1){1'b1}}};
    else if (v < lo) return {1'b1, {(POS_W-1){1'b0}}};
    else             return v[POS_W-1:0];
  endfunction

  logic en;

  // input register
  logic    t0_v_r;
  cvb_in_t t0_d_r;

  // backward normalizer
  logic [2:0][NORM_IN_W-1:0] n1_vec;
  logic [S1_W-1:0]           n1_side_in, n1_side;
  logic                      n1_v, n1_ok;
  logic [2:0][DIR_W-1:0]     n1_dir;
  logic [2:0][POS_W-1:0]     n1_pos;
  logic [2:0][DIR_W-1:0]     n1_up;

  // up x z
  logic                      p1_v_r;
  logic [5:0][PROD_W-1:0]    p1_prod_r, p1_prod_nxt;
  logic [2:0][POS_W-1:0]     p1_pos_r;
  logic [2:0][DIR_W-1:0]     p1_z_r;
  logic                      p1_ok_r;
  logic                      p2_v_r;
  logic [2:0][CROSS_W-1:0]   p2_c_r, p2_c_nxt;
  logic [2:0][POS_W-1:0]     p2_pos_r;
  logic [2:0][DIR_W-1:0]     p2_z_r;
  logic                      p2_ok_r;

  // right normalizer
  logic [S2_W-1:0]           n2_side_in, n2_side;
  logic                      n2_v, n2_ok;
  logic [2:0][DIR_W-1:0]     n2_dir;
  logic [2:0][POS_W-1:0]     n2_pos;
  logic [2:0][DIR_W-1:0]     n2_z;
  logic                      n2_ok1;

  // masked axes
  logic                      m_v_r;
  logic [2:0][DIR_W-1:0]     m_x_r, m_z_r;
  logic [2:0][POS_W-1:0]     m_pos_r;
  logic                      m_ok;

  // z x x
  logic                      y1_v_r;
  logic [5:0][PROD_W-1:0]    y1_prod_r, y1_prod_nxt;
  logic [2:0][DIR_W-1:0]     y1_x_r, y1_z_r;
  logic [2:0][POS_W-1:0]     y1_pos_r;
  logic                      y2_v_r;
  logic [2:0][CROSS_W-1:0]   y2_c_r, y2_c_nxt;
  logic [2:0][DIR_W-1:0]     y2_x_r, y2_z_r;
  logic [2:0][POS_W-1:0]     y2_pos_r;
  logic                      y3_v_r;
  logic [2:0][DIR_W-1:0]     y3_y_r, y3_y_nxt;
  logic [2:0][DIR_W-1:0]     y3_x_r, y3_z_r;
  logic [2:0][POS_W-1:0]     y3_pos_r;
  logic signed [RND_W-1:0]   y_rnd [3];

  // translation
  logic                      d1_v_r;
  logic [8:0][DOTP_W-1:0]    d1_prod_r, d1_prod_nxt;
  logic [2:0][DIR_W-1:0]     d1_x_r, d1_y_r, d1_z_r;
  logic [2:0][DIR_W-1:0]     d1_axis [3];
  logic                      d2_v_r;
  logic [2:0][DOTS_W-1:0]    d2_sum_r, d2_sum_nxt;
  logic [2:0][DIR_W-1:0]     d2_x_r, d2_y_r, d2_z_r;
  logic                      d3_v_r;
  cvb_out_t                  d3_d_r, d3_d_nxt;
  logic signed [NEG_W-1:0]   d_neg [3];

  // output buffer
  logic     out_v_r, skid_v_r;
  cvb_out_t out_d_r, skid_d_r;
  logic     out_take, exit_v;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else if (en) begin
      t0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d_r <= in_data;
    end
  end

  assign n1_vec[0] = NORM_IN_W'(t0_d_r.back_x);
  assign n1_vec[1] = NORM_IN_W'(t0_d_r.back_y);
  assign n1_vec[2] = NORM_IN_W'(t0_d_r.back_z);
  assign n1_side_in = {t0_d_r.pos_z, t0_d_r.pos_y, t0_d_r.pos_x,
                       t0_d_r.up_z, t0_d_r.up_y, t0_d_r.up_x};

  cvb_norm #(
    .SIDE_W (S1_W)
  ) u_norm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (t0_v_r),
    .in_vec   (n1_vec),
    .in_side  (n1_side_in),
    .out_v    (n1_v),
    .out_ok   (n1_ok),
    .out_dir  (n1_dir),
    .out_side (n1_side)
  );

  assign {n1_pos, n1_up} = n1_side;

  always_comb begin
    p1_prod_nxt[0] = PROD_W'($signed(n1_up[1]) * $signed(n1_dir[2]));
    p1_prod_nxt[1] = PROD_W'($signed(n1_up[2]) * $signed(n1_dir[1]));
    p1_prod_nxt[2] = PROD_W'($signed(n1_up[2]) * $signed(n1_dir[0]));
    p1_prod_nxt[3] = PROD_W'($signed(n1_up[0]) * $signed(n1_dir[2]));
    p1_prod_nxt[4] = PROD_W'($signed(n1_up[0]) * $signed(n1_dir[1]));
    p1_prod_nxt[5] = PROD_W'($signed(n1_up[1]) * $signed(n1_dir[0]));
    for (int i = 0; i < 3; i++) begin
      p2_c_nxt[i] = CROSS_W'($signed(p1_prod_r[2*i]))
                  - CROSS_W'($signed(p1_prod_r[2*i+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= n1_v;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prod_r <= p1_prod_nxt;
      p1_pos_r  <= n1_pos;
      p1_z_r    <= n1_dir;
      p1_ok_r   <= n1_ok;
      p2_c_r    <= p2_c_nxt;
      p2_pos_r  <= p1_pos_r;
      p2_z_r    <= p1_z_r;
      p2_ok_r   <= p1_ok_r;
    end
  end

  assign n2_side_in = {p2_pos_r, p2_z_r, p2_ok_r};

  cvb_norm #(
    .SIDE_W (S2_W)
  ) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (p2_v_r),
    .in_vec   (p2_c_r),
    .in_side  (n2_side_in),
    .out_v    (n2_v),
    .out_ok   (n2_ok),
    .out_dir  (n2_dir),
    .out_side (n2_side)
  );

  assign {n2_pos, n2_z, n2_ok1} = n2_side;
  assign m_ok = n2_ok && n2_ok1;

  always_comb begin
    y1_prod_nxt[0] = PROD_W'($signed(m_z_r[1]) * $signed(m_x_r[2]));
    y1_prod_nxt[1] = PROD_W'($signed(m_z_r[2]) * $signed(m_x_r[1]));
    y1_prod_nxt[2] = PROD_W'($signed(m_z_r[2]) * $signed(m_x_r[0]));
    y1_prod_nxt[3] = PROD_W'($signed(m_z_r[0]) * $signed(m_x_r[2]));
    y1_prod_nxt[4] = PROD_W'($signed(m_z_r[0]) * $signed(m_x_r[1]));
    y1_prod_nxt[5] = PROD_W'($signed(m_z_r[1]) * $signed(m_x_r[0]));
    for (int i = 0; i < 3; i++) begin
      y2_c_nxt[i] = CROSS_W'($signed(y1_prod_r[2*i]))
                  - CROSS_W'($signed(y1_prod_r[2*i+1]));
      y_rnd[i]    = (RND_W'($signed(y2_c_r[i])) + RND_W'(1 << (DIR_FRAC_BITS - 1)))
                    >>> DIR_FRAC_BITS;
      y3_y_nxt[i] = sat_dir(y_rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
      y3_v_r <= 1'b0;
    end else if (en) begin
      m_v_r  <= n2_v;
      y1_v_r <= m_v_r;
      y2_v_r <= y1_v_r;
      y3_v_r <= y2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x_r     <= m_ok ? n2_dir : '0;
      m_z_r     <= m_ok ? n2_z : '0;
      m_pos_r   <= n2_pos;
      y1_prod_r <= y1_prod_nxt;
      y1_x_r    <= m_x_r;
      y1_z_r    <= m_z_r;
      y1_pos_r  <= m_pos_r;
      y2_c_r    <= y2_c_nxt;
      y2_x_r    <= y1_x_r;
      y2_z_r    <= y1_z_r;
      y2_pos_r  <= y1_pos_r;
      y3_y_r    <= y3_y_nxt;
      y3_x_r    <= y2_x_r;
      y3_z_r    <= y2_z_r;
      y3_pos_r  <= y2_pos_r;
    end
  end

  assign d1_axis[0] = y3_x_r;
  assign d1_axis[1] = y3_y_r;
  assign d1_axis[2] = y3_z_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        d1_prod_nxt[3*k+i] = DOTP_W'($signed(d1_axis[k][i]) * $signed(y3_pos_r[i]));
      end
      d2_sum_nxt[k] = DOTS_W'($signed(d1_prod_r[3*k]))
                    + DOTS_W'($signed(d1_prod_r[3*k+1]))
                    + DOTS_W'($signed(d1_prod_r[3*k+2]));
      d_neg[k] = ((NEG_W'(0) - NEG_W'($signed(d2_sum_r[k])))
                  + NEG_W'(1 << (DIR_FRAC_BITS - 1))) >>> DIR_FRAC_BITS;
    end
    d3_d_nxt.right_x    = d2_x_r[0];
    d3_d_nxt.right_y    = d2_x_r[1];
    d3_d_nxt.right_z    = d2_x_r[2];
    d3_d_nxt.upward_x   = d2_y_r[0];
    d3_d_nxt.upward_y   = d2_y_r[1];
    d3_d_nxt.upward_z   = d2_y_r[2];
    d3_d_nxt.backward_x = d2_z_r[0];
    d3_d_nxt.backward_y = d2_z_r[1];
    d3_d_nxt.backward_z = d2_z_r[2];
    d3_d_nxt.shift_x    = sat_pos(d_neg[0]);
    d3_d_nxt.shift_y    = sat_pos(d_neg[1]);
    d3_d_nxt.shift_z    = sat_pos(d_neg[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= y3_v_r;
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_prod_r <= d1_prod_nxt;
      d1_x_r    <= y3_x_r;
      d1_y_r    <= y3_y_r;
      d1_z_r    <= y3_z_r;
      d2_sum_r  <= d2_sum_nxt;
      d2_x_r    <= d1_x_r;
      d2_y_r    <= d1_y_r;
      d2_z_r    <= d1_z_r;
      d3_d_r    <= d3_d_nxt;
    end
  end

  // output register plus skid entry
  assign out_take = out_v_r && !out_stall;
  assign exit_v   = en && d3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= exit_v;
      end
    end else if (exit_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_take) begin
      out_d_r <= skid_v_r ? skid_d_r : d3_d_r;
    end else if (exit_v) begin
      skid_d_r <= d3_d_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall && d3_v_r))
    else $error("skid entry filled without a held result");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && d3_v_r) |=> d3_v_r)
    else $error("pipeline moved while output buffer full");
`endif

endmodule

@@ hw/rtl/cvb_norm.sv @@
`timescale 1ns / 1ps

module cvb_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic [2:0][cvb_pkg::NORM_IN_W-1:0]  in_vec,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_v,
  output logic                                out_ok,
  output logic [2:0][cvb_pkg::DIR_W-1:0]      out_dir,
  output logic [SIDE_W-1:0]                   out_side
);
  import cvb_pkg::*;

  localparam int DIV_STEPS = QUO_W;

  // stage a: magnitudes
  logic                      a_v_r;
  logic [2:0][MAG_W-1:0]     a_mag_r, a_mag_nxt;
  logic [2:0]                a_neg_r, a_neg_nxt;
  logic [SIDE_W-1:0]         a_side_r;
  logic [NORM_IN_W-1:0]      a_abs [3];

  // stage b: shift amount
  logic                      b_v_r;
  logic [2:0][MAG_W-1:0]     b_mag_r;
  logic [2:0]                b_neg_r;
  logic [SIDE_W-1:0]         b_side_r;
  logic [SH_W-1:0]           b_sh_r, b_sh_nxt;
  logic [MAG_W-1:0]          b_or;
  logic [SH_W-1:0]           b_hsel;

  // stage c: scaled components
  logic                      c_v_r;
  logic [2:0][M_W-1:0]       c_m_r, c_m_nxt;
  logic [2:0]                c_neg_r;
  logic [SIDE_W-1:0]         c_side_r;
  logic [MAG_W-1:0]          c_shifted [3];

  // stage d: squares
  logic                      d_v_r;
  logic [2:0][SQ_W-1:0]      d_sq_r;
  logic [2:0][M_W-1:0]       d_m_r;
  logic [2:0]                d_neg_r;
  logic [SIDE_W-1:0]         d_side_r;

  // stage e: squared length
  logic                      e_v_r;
  logic [LEN_W-1:0]          e_len_r;
  logic                      e_ok_r;
  logic [2:0][M_W-1:0]       e_m_r;
  logic [2:0]                e_neg_r;
  logic [SIDE_W-1:0]         e_side_r;

  // square root steps
  logic [SQRT_STEPS-1:0]     sr_v_r;
  logic [ROOT_W-1:0]         sr_x_r [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_res_r [SQRT_STEPS];
  logic [2:0][M_W-1:0]       sr_m_r [SQRT_STEPS];
  logic [2:0]                sr_neg_r [SQRT_STEPS];
  logic                      sr_ok_r [SQRT_STEPS];
  logic [SIDE_W-1:0]         sr_side_r [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_xi [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_ri [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_tr [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_x_nxt [SQRT_STEPS];
  logic [ROOT_W-1:0]         sr_res_nxt [SQRT_STEPS];

  // stage f: dividends
  logic                      f_v_r;
  logic [2:0][NUM_W-1:0]     f_num_r, f_num_nxt;
  logic [S_W-1:0]            f_s_r, f_s_nxt;
  logic [2:0]                f_neg_r;
  logic                      f_ok_r;
  logic [SIDE_W-1:0]         f_side_r;

  // divide steps
  logic [DIV_STEPS-1:0]      dv_v_r;
  logic [2:0][NUM_W-1:0]     dv_rem_r [DIV_STEPS];
  logic [2:0][QUO_W-1:0]     dv_q_r [DIV_STEPS];
  logic [S_W-1:0]            dv_s_r [DIV_STEPS];
  logic [2:0]                dv_neg_r [DIV_STEPS];
  logic                      dv_ok_r [DIV_STEPS];
  logic [SIDE_W-1:0]         dv_side_r [DIV_STEPS];
  logic [2:0][NUM_W-1:0]     dv_ri [DIV_STEPS];
  logic [2:0][QUO_W-1:0]     dv_qi [DIV_STEPS];
  logic [S_W-1:0]            dv_si [DIV_STEPS];
  logic [NUM_W:0]            dv_t [DIV_STEPS];
  logic [2:0][NUM_W-1:0]     dv_rem_nxt [DIV_STEPS];
  logic [2:0][QUO_W-1:0]     dv_q_nxt [DIV_STEPS];

  // stage g: signed result
  logic                      g_v_r;
  logic [2:0][DIR_W-1:0]     g_dir_r, g_dir_nxt;
  logic                      g_ok_r;
  logic [SIDE_W-1:0]         g_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_neg_nxt[i] = in_vec[i][NORM_IN_W-1];
      a_abs[i]     = a_neg_nxt[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
      a_mag_nxt[i] = a_abs[i][MAG_W-1:0];
    end
  end

  always_comb begin
    b_or   = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    b_hsel = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (b_or[j]) begin
        b_hsel = SH_W'(j);
      end
    end
    b_sh_nxt = (b_hsel >= SH_W'(M_W)) ? (b_hsel - SH_W'(M_W - 1)) : '0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_shifted[i] = b_mag_r[i] >> b_sh_r;
      c_m_nxt[i]   = c_shifted[i][M_W-1:0];
    end
  end

  always_comb begin
    sr_xi[0] = {e_len_r, {(ROOT_W - LEN_W){1'b0}}};
    sr_ri[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sr_xi[k] = sr_x_r[k-1];
      sr_ri[k] = sr_res_r[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sr_tr[k] = sr_ri[k] + (ROOT_W'(1) << (ROOT_W - 2 - 2 * k));
      if (sr_xi[k] >= sr_tr[k]) begin
        sr_x_nxt[k]   = sr_xi[k] - sr_tr[k];
        sr_res_nxt[k] = (sr_ri[k] >> 1) + (ROOT_W'(1) << (ROOT_W - 2 - 2 * k));
      end else begin
        sr_x_nxt[k]   = sr_xi[k];
        sr_res_nxt[k] = sr_ri[k] >> 1;
      end
    end
  end

  always_comb begin
    f_s_nxt = sr_res_r[SQRT_STEPS-1][S_W-1:0];
    for (int i = 0; i < 3; i++) begin
      f_num_nxt[i] = NUM_W'({sr_m_r[SQRT_STEPS-1][i], {NUM_SHIFT{1'b0}}})
                   + NUM_W'(f_s_nxt >> 1);
    end
  end

  always_comb begin
    dv_ri[0] = f_num_r;
    dv_qi[0] = '0;
    dv_si[0] = f_s_r;
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_ri[k] = dv_rem_r[k-1];
      dv_qi[k] = dv_q_r[k-1];
      dv_si[k] = dv_s_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_t[k]       = (NUM_W+1)'(dv_si[k]) << (QUO_W - 1 - k);
      dv_rem_nxt[k] = dv_ri[k];
      dv_q_nxt[k]   = dv_qi[k];
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, dv_ri[k][i]} >= dv_t[k]) begin
          dv_rem_nxt[k][i]              = dv_ri[k][i] - dv_t[k][NUM_W-1:0];
          dv_q_nxt[k][i][QUO_W-1-k]     = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_ok_r[DIV_STEPS-1]) begin
        g_dir_nxt[i] = '0;
      end else if (dv_neg_r[DIV_STEPS-1][i]) begin
        g_dir_nxt[i] = DIR_W'(0) - {1'b0, dv_q_r[DIV_STEPS-1][i]};
      end else begin
        g_dir_nxt[i] = {1'b0, dv_q_r[DIV_STEPS-1][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
      sr_v_r <= '0;
      f_v_r  <= 1'b0;
      dv_v_r <= '0;
      g_v_r  <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_v;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= d_v_r;
      sr_v_r <= {sr_v_r[SQRT_STEPS-2:0], e_v_r};
      f_v_r  <= sr_v_r[SQRT_STEPS-1];
      dv_v_r <= {dv_v_r[DIV_STEPS-2:0], f_v_r};
      g_v_r  <= dv_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= a_mag_nxt;
      a_neg_r  <= a_neg_nxt;
      a_side_r <= in_side;

      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_side_r <= a_side_r;
      b_sh_r   <= b_sh_nxt;

      c_m_r    <= c_m_nxt;
      c_neg_r  <= b_neg_r;
      c_side_r <= b_side_r;

      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= SQ_W'(c_m_r[i]) * SQ_W'(c_m_r[i]);
      end
      d_m_r    <= c_m_r;
      d_neg_r  <= c_neg_r;
      d_side_r <= c_side_r;

      e_len_r  <= LEN_W'(d_sq_r[0]) + LEN_W'(d_sq_r[1]) + LEN_W'(d_sq_r[2]);
      e_ok_r   <= |{d_m_r[0], d_m_r[1], d_m_r[2]};
      e_m_r    <= d_m_r;
      e_neg_r  <= d_neg_r;
      e_side_r <= d_side_r;

      for (int k = 0; k < SQRT_STEPS; k++) begin
        sr_x_r[k]   <= sr_x_nxt[k];
        sr_res_r[k] <= sr_res_nxt[k];
      end
      sr_m_r[0]    <= e_m_r;
      sr_neg_r[0]  <= e_neg_r;
      sr_ok_r[0]   <= e_ok_r;
      sr_side_r[0] <= e_side_r;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sr_m_r[k]    <= sr_m_r[k-1];
        sr_neg_r[k]  <= sr_neg_r[k-1];
        sr_ok_r[k]   <= sr_ok_r[k-1];
        sr_side_r[k] <= sr_side_r[k-1];
      end

      f_num_r  <= f_num_nxt;
      f_s_r    <= f_s_nxt;
      f_neg_r  <= sr_neg_r[SQRT_STEPS-1];
      f_ok_r   <= sr_ok_r[SQRT_STEPS-1];
      f_side_r <= sr_side_r[SQRT_STEPS-1];

      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
        dv_s_r[k]   <= dv_si[k];
      end
      dv_neg_r[0]  <= f_neg_r;
      dv_ok_r[0]   <= f_ok_r;
      dv_side_r[0] <= f_side_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_neg_r[k]  <= dv_neg_r[k-1];
        dv_ok_r[k]   <= dv_ok_r[k-1];
        dv_side_r[k] <= dv_side_r[k-1];
      end

      g_dir_r  <= g_dir_nxt;
      g_ok_r   <= dv_ok_r[DIV_STEPS-1];
      g_side_r <= dv_side_r[DIV_STEPS-1];
    end
  end

  assign out_v    = g_v_r;
  assign out_ok   = g_ok_r;
  assign out_dir  = g_dir_r;
  assign out_side = g_side_r;

endmodule
